// File: src/edd_pkg.sv
// Package for the error diffusion dither block: widths, codes, state type
// and the share/saturation helpers. No dependencies.
`default_nettype none

package edd_pkg;

    localparam int FRAC_BITS = 16;
    localparam int SAMPLE_W  = 16;
    localparam int LEVEL_W   = 8;
    localparam int VALUE_W   = 17;
    localparam int ERR_W     = 20;
    localparam int V_W       = 22;            // corrected sample and error
    localparam int MA_W      = 23;            // multiplier operand a
    localparam int MB_W      = 18;            // multiplier operand b
    localparam int P_W       = MA_W + MB_W;   // product
    localparam int SUM_W     = 26;            // share arithmetic

    localparam logic [VALUE_W-1:0] ONE = VALUE_W'(1) << FRAC_BITS;

    localparam logic signed [SUM_W-1:0] ERR_MAX = SUM_W'((1 << (ERR_W - 1)) - 1);
    localparam logic signed [SUM_W-1:0] ERR_MIN = SUM_W'(-(1 << (ERR_W - 1)));
    localparam logic signed [SUM_W-1:0] SHARE_RND = SUM_W'(8);

    // diffusion weights in sixteenths
    localparam logic [2:0] K_RIGHT      = 3'd7;
    localparam logic [2:0] K_BELOW_LEFT = 3'd3;
    localparam logic [2:0] K_BELOW      = 3'd5;
    localparam logic [2:0] K_BELOW_RT   = 3'd1;

    // register map, index = paddr[4:2]
    localparam logic [2:0] REG_LINE_WIDTH    = 3'd0;
    localparam logic [2:0] REG_FRAME_HEIGHT  = 3'd1;
    localparam logic [2:0] REG_CHANNEL_COUNT = 3'd2;
    localparam logic [2:0] REG_LEVELS        = 3'd3;
    localparam logic [2:0] REG_LEVEL_STEP    = 3'd4;

    typedef enum logic [1:0] {
        MUL_LEVEL,
        MUL_STEP,
        MUL_ERR
    } mul_op_t;

    typedef struct packed {
        logic    en;
        mul_op_t op;
        logic [2:0] k;
    } mul_req_t;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_SUM   = 11'b000_0000_0010,
        S_MULQ  = 11'b000_0000_0100,
        S_QUANT = 11'b000_0000_1000,
        S_MULV  = 11'b000_0001_0000,
        S_ERR   = 11'b000_0010_0000,
        S_SH7   = 11'b000_0100_0000,
        S_SH3   = 11'b000_1000_0000,
        S_SH5   = 11'b001_0000_0000,
        S_SH1   = 11'b010_0000_0000,
        S_DONE  = 11'b100_0000_0000
    } state_t;

    // (p + 8) >>> 4, rounds to nearest, halves upward
    function automatic logic signed [SUM_W-1:0] share(input logic signed [SUM_W-1:0] p);
        share = (p + SHARE_RND) >>> 4;
    endfunction

    function automatic logic signed [ERR_W-1:0] sat_err(input logic signed [SUM_W-1:0] x);
        logic signed [ERR_W-1:0] r;
        if (x > ERR_MAX) begin
            r = ERR_MAX[ERR_W-1:0];
        end else if (x < ERR_MIN) begin
            r = ERR_MIN[ERR_W-1:0];
        end else begin
            r = x[ERR_W-1:0];
        end
        sat_err = r;
    endfunction

endpackage

`default_nettype wire

// File: src/edd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module edd_ram #(
    parameter int DATA_W = 20,
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = 12
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: src/edd_mul.sv
// Shared multiplier of the dither datapath: operand select per request,
// registered product. Depends on edd_pkg.
`default_nettype none

module edd_mul
    import edd_pkg::*;
(
    input  logic                       clk,
    input  mul_req_t                   req,
    input  logic signed [V_W-1:0]      v,
    input  logic signed [V_W-1:0]      e,
    input  logic [LEVEL_W-1:0]         lv,
    input  logic [LEVEL_W-1:0]         q,
    input  logic [VALUE_W-1:0]         step,
    output logic signed [P_W-1:0]      prod
);

    logic signed [MA_W-1:0] op_a;
    logic signed [MB_W-1:0] op_b;
    logic signed [P_W-1:0]  prod_full;
    logic signed [P_W-1:0]  prod_reg;

    always_comb
    begin
        unique case (req.op)
            MUL_LEVEL:
            begin
                op_a = MA_W'(v);
                op_b = $signed({{(MB_W-LEVEL_W){1'b0}}, lv});
            end
            MUL_STEP:
            begin
                op_a = $signed({{(MA_W-LEVEL_W){1'b0}}, q});
                op_b = $signed({{(MB_W-VALUE_W){1'b0}}, step});
            end
            MUL_ERR:
            begin
                op_a = MA_W'(e);
                op_b = $signed({{(MB_W-3){1'b0}}, req.k});
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    // operands sign-extend to the full product width
    assign prod_full = op_a * op_b;

    always_ff @(posedge clk)
    begin
        if (req.en)
        begin
            prod_reg <= prod_full;
        end
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

// File: src/error_diffusion_dither.sv
// Top level of the multilevel error diffusion (Floyd-Steinberg) ditherer.
// Depends on edd_pkg, edd_mul and edd_ram.
//
// Usage:
//  - Input channel: in_valid / in_stall with sample (unsigned Q0.16). Samples
//    come in raster order, channels of a pixel interleaved.
//  - Output channel: out_valid / out_stall with level_index, quant_value and
//    frame_end. Exactly one result per request, in order.
//  - APB port sets line_width, frame_height, channel_count, levels and
//    level_step (byte address 4*i). Write only while no request is in flight.
//  - Timing: a request steps through SUM, MULQ, QUANT, MULV, ERR, SH7, SH3, SH5,
//    SH1 and DONE to the output register; no new request is taken before IDLE.
//    The pace is set by the single shared multiplier: v*levels, q*level_step and
//    the four error shares go through it one after another, each product registered.
//  - in_stall is high while a request is being worked on.
//  - The output register decouples the sides: a new request is taken while
//    a result waits; a held output only delays the next result's write-back.
//  - Reset: registers to their defaults, counters and carries to zero. The
//    next-row error buffer is not cleared; row 0 never reads it.
//  - Position counters wrap at frame end, flagged by frame_end.
`default_nettype none

module error_diffusion_dither
    import edd_pkg::*;
#(
    parameter int MAX_WIDTH    = 1024,
    parameter int MAX_HEIGHT   = 1024,
    parameter int MAX_CHANNELS = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    // configuration
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    // sample stream
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [SAMPLE_W-1:0] sample,
    // result stream
    output logic                out_valid,
    input  logic                out_stall,
    output logic [LEVEL_W-1:0]  level_index,
    output logic [VALUE_W-1:0]  quant_value,
    output logic                frame_end
);

    localparam int XW        = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int YW        = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int CW        = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int AW        = XW + CW;
    localparam int RAM_DEPTH = MAX_WIDTH << CW;
    localparam int POS_W     = (XW > YW) ? XW : YW;
    localparam int CMP_W     = ((POS_W > 11) ? POS_W : 11) + 1;

    // configuration registers
    logic [10:0]         line_width_reg;
    logic [10:0]         frame_height_reg;
    logic [2:0]          channel_count_reg;
    logic [LEVEL_W-1:0]  levels_reg;
    logic [VALUE_W-1:0]  level_step_reg;
    logic                cfg_write;
    logic [2:0]          cfg_index;

    // sequencer and datapath
    state_t                  state_reg, state_next;
    logic [SAMPLE_W-1:0]     sample_reg;
    logic signed [V_W-1:0]   v_reg;
    logic signed [V_W-1:0]   e_reg;
    logic [LEVEL_W-1:0]      q_reg;
    logic [VALUE_W-1:0]      value_reg;
    logic signed [ERR_W-1:0] left_reg;
    logic signed [ERR_W-1:0] rc_reg   [MAX_CHANNELS];
    logic signed [ERR_W-1:0] diag_reg [MAX_CHANNELS];

    logic [XW-1:0] col_reg, col_next;
    logic [YW-1:0] row_reg, row_next;
    logic [CW-1:0] ch_reg, ch_next;

    logic                out_valid_reg, out_valid_next;
    logic [LEVEL_W-1:0]  level_index_reg;
    logic [VALUE_W-1:0]  quant_value_reg;
    logic                frame_end_reg;

    logic                in_accept;
    logic                done_go;
    logic [LEVEL_W-1:0]  lv_eff;
    logic [CMP_W-1:0]    col1, row1, ch1;
    logic                has_right, has_below, has_left;
    logic                last_c, last_x, last_y;

    logic [AW-1:0]       idx_addr, left_addr;
    logic                ram_we, ram_re;
    logic [AW-1:0]       ram_waddr, ram_raddr;
    logic [ERR_W-1:0]    ram_wdata, ram_rdata;

    mul_req_t                mul_req;
    logic signed [P_W-1:0]   prod;
    logic signed [SUM_W-1:0] sh;

    logic signed [V_W-1:0]   v_sum;
    logic [P_W-1:0]          q_sum;
    logic [P_W-FRAC_BITS-1:0] q_raw;
    logic [LEVEL_W-1:0]      q_calc;
    logic [VALUE_W-1:0]      value_calc;
    logic signed [V_W-1:0]   e_calc;

    //--------------------------------------------------------------------
    // APB register file
    //--------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg    <= 11'd1024;
            frame_height_reg  <= 11'd1024;
            channel_count_reg <= 3'd1;
            levels_reg        <= 8'd1;
            level_step_reg    <= ONE;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_LINE_WIDTH:    line_width_reg    <= pwdata[10:0];
                REG_FRAME_HEIGHT:  frame_height_reg  <= pwdata[10:0];
                REG_CHANNEL_COUNT: channel_count_reg <= pwdata[2:0];
                REG_LEVELS:        levels_reg        <= pwdata[LEVEL_W-1:0];
                REG_LEVEL_STEP:    level_step_reg    <= pwdata[VALUE_W-1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_index)
            REG_LINE_WIDTH:    prdata = 32'(line_width_reg);
            REG_FRAME_HEIGHT:  prdata = 32'(frame_height_reg);
            REG_CHANNEL_COUNT: prdata = 32'(channel_count_reg);
            REG_LEVELS:        prdata = 32'(levels_reg);
            REG_LEVEL_STEP:    prdata = 32'(level_step_reg);
            default:           prdata = '0;
        endcase
    end

    //--------------------------------------------------------------------
    // Position and edge flags (config is to be kept stable by the user while a request runs; not enforced here)
    //--------------------------------------------------------------------
    assign lv_eff = (levels_reg == '0) ? LEVEL_W'(1) : levels_reg;

    assign col1 = CMP_W'(col_reg) + CMP_W'(1);
    assign row1 = CMP_W'(row_reg) + CMP_W'(1);
    assign ch1  = CMP_W'(ch_reg) + CMP_W'(1);

    // a zero register clamps to one, so "next < reg" covers it
    assign has_right = (col1 < CMP_W'(line_width_reg)) && (col1 < CMP_W'(MAX_WIDTH));
    assign has_below = (row1 < CMP_W'(frame_height_reg)) && (row1 < CMP_W'(MAX_HEIGHT));
    assign has_left  = (col_reg != '0);
    assign last_c    = !((ch1 < CMP_W'(channel_count_reg)) && (ch1 < CMP_W'(MAX_CHANNELS)));
    assign last_x    = !has_right;
    assign last_y    = !has_below;

    assign idx_addr  = {col_reg, ch_reg};
    assign left_addr = {col_reg - XW'(1), ch_reg};

    //--------------------------------------------------------------------
    // Sequencer
    //--------------------------------------------------------------------
    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign done_go   = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (in_accept) state_next = S_SUM;
            S_SUM:   state_next = S_MULQ;
            S_MULQ:  state_next = S_QUANT;
            S_QUANT: state_next = S_MULV;
            S_MULV:  state_next = S_ERR;
            S_ERR:   state_next = S_SH7;
            S_SH7:   state_next = S_SH3;
            S_SH3:   state_next = S_SH5;
            S_SH5:   state_next = S_SH1;
            S_SH1:   state_next = S_DONE;
            S_DONE:  if (done_go) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // shared multiplier requests
    always_comb
    begin
        mul_req = '{en: 1'b0, op: MUL_ERR, k: K_BELOW_RT};
        unique case (state_reg)
            S_MULQ:  mul_req = '{en: 1'b1, op: MUL_LEVEL, k: K_BELOW_RT};
            S_MULV:  mul_req = '{en: 1'b1, op: MUL_STEP,  k: K_BELOW_RT};
            S_SH7:   mul_req = '{en: 1'b1, op: MUL_ERR,   k: K_RIGHT};
            S_SH3:   mul_req = '{en: 1'b1, op: MUL_ERR,   k: K_BELOW_LEFT};
            S_SH5:   mul_req = '{en: 1'b1, op: MUL_ERR,   k: K_BELOW};
            S_SH1:   mul_req = '{en: 1'b1, op: MUL_ERR,   k: K_BELOW_RT};
            default: ;
        endcase
    end

    edd_mul u_mul (
        .clk  (clk),
        .req  (mul_req),
        .v    (v_reg),
        .e    (e_reg),
        .lv   (lv_eff),
        .q    (q_reg),
        .step (level_step_reg),
        .prod (prod)
    );

    // share of the last error product, (p+8)>>>4
    assign sh = share(prod[SUM_W-1:0]);

    //--------------------------------------------------------------------
    // Next-row error buffer: read own entry at accept, left entry in SUM;
    // write left entry in SH5, own entry in SH1.
    //--------------------------------------------------------------------
    assign ram_re    = in_accept || (state_reg == S_SUM);
    assign ram_raddr = (state_reg == S_SUM) ? left_addr : idx_addr;

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = idx_addr;
        ram_wdata = sat_err(SUM_W'(diag_reg[ch_reg]) + sh);
        if (state_reg == S_SH5)
        begin
            ram_we    = has_below && has_left;
            ram_waddr = left_addr;
            ram_wdata = sat_err(SUM_W'(left_reg) + sh);
        end
        else if (state_reg == S_SH1)
        begin
            ram_we = has_below;
        end
    end

    edd_ram #(
        .DATA_W (ERR_W),
        .DEPTH  (RAM_DEPTH),
        .ADDR_W (AW)
    ) u_row_buf (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    //--------------------------------------------------------------------
    // Datapath arithmetic
    //--------------------------------------------------------------------
    // row 0 ignores the buffer
    assign v_sum = $signed({{(V_W-SAMPLE_W){1'b0}}, sample_reg}) + V_W'(rc_reg[ch_reg])
                 + ((row_reg != '0) ? V_W'($signed(ram_rdata)) : V_W'(0));

    // q = round(v*levels / ONE), clamped; non-positive v gives zero
    assign q_sum  = prod + (P_W'(1) << (FRAC_BITS - 1));
    assign q_raw  = q_sum[P_W-1:FRAC_BITS];
    assign q_calc = (v_reg <= V_W'(0)) ? '0 :
                    ((q_raw > (P_W-FRAC_BITS)'(lv_eff)) ? lv_eff : q_raw[LEVEL_W-1:0]);

    // top level is exactly ONE; oversized products saturate
    assign value_calc = (q_reg == lv_eff) ? ONE :
                        ((prod > $signed(P_W'(ONE))) ? ONE : prod[VALUE_W-1:0]);
    assign e_calc = v_reg - $signed({{(V_W-VALUE_W){1'b0}}, value_calc});

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            sample_reg <= sample;
        end
        if (state_reg == S_SUM)
        begin
            v_reg <= v_sum;
        end
        if (state_reg == S_MULQ)
        begin
            left_reg <= $signed(ram_rdata);
        end
        if (state_reg == S_QUANT)
        begin
            q_reg <= q_calc;
        end
        if (state_reg == S_ERR)
        begin
            value_reg <= value_calc;
            e_reg     <= e_calc;
        end
        if (done_go)
        begin
            level_index_reg <= q_reg;
            quant_value_reg <= value_reg;
            frame_end_reg   <= last_c && last_x && last_y;
        end
    end

    // per-channel carries
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_CHANNELS; i++)
            begin
                rc_reg[i]   <= '0;
                diag_reg[i] <= '0;
            end
        end
        else
        begin
            if (state_reg == S_SH3)
            begin
                rc_reg[ch_reg] <= has_right ? sat_err(sh) : '0;
            end
            if (done_go)
            begin
                diag_reg[ch_reg] <= (has_below && has_right) ? sat_err(sh) : '0;
            end
        end
    end

    //--------------------------------------------------------------------
    // Counters, output valid, state
    //--------------------------------------------------------------------
    always_comb
    begin
        ch_next  = ch_reg;
        col_next = col_reg;
        row_next = row_reg;
        if (done_go)
        begin
            if (!last_c)
            begin
                ch_next = ch_reg + CW'(1);
            end
            else
            begin
                ch_next = '0;
                if (!last_x)
                begin
                    col_next = col_reg + XW'(1);
                end
                else
                begin
                    col_next = '0;
                    row_next = last_y ? '0 : row_reg + YW'(1);
                end
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (done_go)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            col_reg       <= '0;
            row_reg       <= '0;
            ch_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            ch_reg        <= ch_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign level_index = level_index_reg;
    assign quant_value = quant_value_reg;
    assign frame_end   = frame_end_reg;

    //--------------------------------------------------------------------
    // Assertions
    //--------------------------------------------------------------------
    a_ram_port_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re))
        else $error("row buffer read and write in the same cycle");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (state_reg == S_SUM))
        else $error("accepted request did not start the sequence");

    a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
        done_go |=> (out_valid_reg && (level_index_reg <= $past(lv_eff))
                     && (quant_value_reg <= ONE)))
        else $error("result out of range");

    a_no_write_last_row: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> has_below)
        else $error("row buffer written on the last row");

endmodule

`default_nettype wire

// File: sim/error_diffusion_dither_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for error_diffusion_dither: sample requests, APB register setup,
// and a behavioral ditherer that predicts every result. Depends on edd_pkg and the RTL.

module error_diffusion_dither_tb
    import edd_pkg::*;
;

    // Geometry limits of the instance (default parameters).
    localparam int     GRID_W  = 1024;
    localparam int     GRID_H  = 1024;
    localparam int     GRID_CH = 4;
    localparam longint UNIT    = longint'(1) << FRAC_BITS;          // 1.0 in Q0.16
    localparam longint ERR_HI  = (longint'(1) << (ERR_W - 1)) - 1;
    localparam longint ERR_LO  = -(longint'(1) << (ERR_W - 1));

    // ------------------------------------------------------------------
    // DUT signals, all inputs known from time zero
    // ------------------------------------------------------------------
    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [4:0]          paddr = '0;
    logic [31:0]         pwdata = '0;
    logic [31:0]         prdata;
    logic                pready;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [SAMPLE_W-1:0] sample = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [LEVEL_W-1:0]  level_index;
    logic [VALUE_W-1:0]  quant_value;
    logic                frame_end;

    error_diffusion_dither dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .sample     (sample),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .level_index(level_index),
        .quant_value(quant_value),
        .frame_end  (frame_end)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Predicted results, oldest first
    // ------------------------------------------------------------------
    typedef struct {
        logic [LEVEL_W-1:0] level;
        logic [VALUE_W-1:0] value;
        logic               last;
    } dither_result_t;

    dither_result_t awaited_results[$];

    int mismatch_count   = 0;
    int requests_sent    = 0;
    int results_checked  = 0;
    int frame_ends_seen  = 0;
    int settings_applied = 0;

    // idle percentages of sender and receiver, changed per phase
    int src_idle_pct  = 0;
    int sink_stall_pct = 0;

    // ------------------------------------------------------------------
    // Behavioral ditherer: register copies, error memories and counters
    // ------------------------------------------------------------------
    longint reg_width, reg_height, reg_chans, reg_levels, reg_step;
    int     below_err [GRID_W*GRID_CH];   // error waiting for the next row
    int     carry_right [GRID_CH];        // 7/16 share for the next pixel
    int     diag_share [GRID_CH];         // 1/16 share of the previous pixel
    longint col_pos, row_pos, chan_pos;

    task automatic note_mismatch(input string what);
        $display("%0t mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    function automatic longint clamp_to(input longint x, input longint lo, input longint hi);
        return (x < lo) ? lo : ((x > hi) ? hi : x);
    endfunction

    function automatic longint sat_error(input longint x);
        return clamp_to(x, ERR_LO, ERR_HI);
    endfunction

    // (e*k + 8) >>> 4, rounds to nearest, halves upward also on negative errors
    function automatic longint spread(input longint e, input longint k);
        return (e * k + 8) >>> 4;
    endfunction

    function automatic logic [31:0] reg_mask(input logic [2:0] idx);
        case (idx)
            REG_LINE_WIDTH, REG_FRAME_HEIGHT: return 32'h7FF;
            REG_CHANNEL_COUNT:                return 32'h7;
            REG_LEVELS:                       return 32'hFF;
            REG_LEVEL_STEP:                   return 32'h1FFFF;
            default:                          return 32'h0;
        endcase
    endfunction

    task automatic model_reset();
        reg_width  = 1024;
        reg_height = 1024;
        reg_chans  = 1;
        reg_levels = 1;
        reg_step   = UNIT;
        foreach (below_err[i]) below_err[i] = 0;
        foreach (carry_right[i]) carry_right[i] = 0;
        foreach (diag_share[i]) diag_share[i] = 0;
        col_pos  = 0;
        row_pos  = 0;
        chan_pos = 0;
    endtask

    // Quantizes one sample, diffuses its error and advances the raster position.
    function automatic dither_result_t dither_predict(input logic [SAMPLE_W-1:0] s);
        longint w, h, nc, lv, v, q, value, e;
        int idx, li, ch;
        bit has_right, has_below, has_left, last_c, last_x, last_y;
        dither_result_t r;
        w  = clamp_to(reg_width, 1, GRID_W);
        h  = clamp_to(reg_height, 1, GRID_H);
        nc = clamp_to(reg_chans, 1, GRID_CH);
        lv = (reg_levels == 0) ? 1 : reg_levels;
        ch = int'(chan_pos);
        idx = int'(col_pos) * GRID_CH + ch;
        has_right = col_pos + 1 < w;
        has_below = row_pos + 1 < h;
        has_left  = col_pos > 0;

        v = longint'(s) + carry_right[ch];
        if (row_pos > 0) v += below_err[idx];   // row 0 never reads the line memory

        if (v <= 0) begin
            q = 0;
        end else begin
            q = (v * lv + (UNIT >>> 1)) >>> FRAC_BITS;
            if (q > lv) q = lv;
        end
        if (q == lv) begin
            value = UNIT;
        end else begin
            value = q * reg_step;
            if (value > UNIT) value = UNIT;     // step too large for this level
        end
        e = v - value;

        carry_right[ch] = has_right ? int'(sat_error(spread(e, 7))) : 0;
        if (has_below) begin
            if (has_left) begin
                li = idx - GRID_CH;
                below_err[li] = int'(sat_error(longint'(below_err[li]) + spread(e, 3)));
            end
            below_err[idx] = int'(sat_error(longint'(diag_share[ch]) + spread(e, 5)));
            diag_share[ch] = has_right ? int'(sat_error(spread(e, 1))) : 0;
        end else begin
            diag_share[ch] = 0;
        end

        last_c = chan_pos + 1 >= nc;
        last_x = col_pos + 1 >= w;
        last_y = row_pos + 1 >= h;
        if (!last_c) begin
            chan_pos++;
        end else begin
            chan_pos = 0;
            if (!last_x) begin
                col_pos++;
            end else begin
                col_pos = 0;
                row_pos = last_y ? 0 : row_pos + 1;
            end
        end

        r.level = q[LEVEL_W-1:0];
        r.value = value[VALUE_W-1:0];
        r.last  = last_c && last_x && last_y;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // APB access: write, then read back the stored (width-masked) value
    // ------------------------------------------------------------------
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        logic [31:0] kept;
        kept = data & reg_mask(idx);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        case (idx)
            REG_LINE_WIDTH:    reg_width  = longint'(kept);
            REG_FRAME_HEIGHT:  reg_height = longint'(kept);
            REG_CHANNEL_COUNT: reg_chans  = longint'(kept);
            REG_LEVELS:        reg_levels = longint'(kept);
            REG_LEVEL_STEP:    reg_step   = longint'(kept);
            default: ;
        endcase
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== kept)
            note_mismatch($sformatf("register %0d reads 0x%0h, written 0x%0h", idx, prdata, kept));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apply_setting(input logic [31:0] w, input logic [31:0] h,
                                 input logic [31:0] nc, input logic [31:0] lv,
                                 input logic [31:0] step);
        write_reg(REG_LINE_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
        write_reg(REG_CHANNEL_COUNT, nc);
        write_reg(REG_LEVELS, lv);
        write_reg(REG_LEVEL_STEP, step);
        settings_applied++;
    endtask

    task automatic set_idling(input int src_pct, input int sink_pct);
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
    endtask

    // ------------------------------------------------------------------
    // Request side. Called just after a rising edge; valid stays high
    // between back-to-back requests and drops only for an idle gap.
    // ------------------------------------------------------------------
    task automatic send_sample(input logic [SAMPLE_W-1:0] s);
        if ($urandom_range(99) < src_idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
        end
        in_valid <= 1'b1;
        sample   <= s;
        do @(posedge clk); while (in_stall);
        awaited_results.push_back(dither_predict(s));
        requests_sent++;
    endtask

    // Block is idle once every predicted result has been taken.
    task automatic drain();
        in_valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge clk);
    endtask

    // Biased toward the ends of the range and the rounding midpoint.
    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            2:       return SAMPLE_W'($urandom_range(16'h7FC0, 16'h8040));
            3:       return SAMPLE_W'($urandom_range(0, 255));
            default: return SAMPLE_W'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic run_samples(input int count);
        for (int i = 0; i < count; i++) send_sample(pick_sample());
    endtask

    // Whole frames only, so the next setting starts at position zero.
    task automatic run_frames(input longint w, input longint h, input longint nc,
                              input longint lv, input longint step, input int frames,
                              output int count);
        count = frames * int'(clamp_to(w, 1, GRID_W) * clamp_to(h, 1, GRID_H)
                              * clamp_to(nc, 1, GRID_CH));
        apply_setting(32'(w), 32'(h), 32'(nc), 32'(lv), 32'(step));
        run_samples(count);
        drain();
    endtask

    // ------------------------------------------------------------------
    // Result side: random stall, field-by-field check against the oldest
    // prediction
    // ------------------------------------------------------------------
    always @(posedge clk) begin : result_check
        dither_result_t want;
        if (rst_n && out_valid && !out_stall) begin
            if (awaited_results.size() == 0) begin
                note_mismatch("result with no request outstanding");
            end else begin
                want = awaited_results.pop_front();
                if (level_index !== want.level)
                    note_mismatch($sformatf("result %0d level_index %0d, predicted %0d",
                                            results_checked, level_index, want.level));
                if (quant_value !== want.value)
                    note_mismatch($sformatf("result %0d quant_value %0d, predicted %0d",
                                            results_checked, quant_value, want.value));
                if (frame_end !== want.last)
                    note_mismatch($sformatf("result %0d frame_end %b, predicted %b",
                                            results_checked, frame_end, want.last));
            end
            if (frame_end === 1'b1) frame_ends_seen++;
            results_checked++;
        end
        out_stall <= ($urandom_range(99) < sink_stall_pct);
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // One 4x3 frame of two channels with the extremes and alternating bit patterns.
    task automatic test_corner_samples();
        set_idling(0, 0);
        apply_setting(4, 3, 2, 4, 16384);
        for (int i = 0; i < 24; i++) begin
            case (i % 8)
                0: send_sample(16'h0000);
                1: send_sample(16'hFFFF);
                2: send_sample(16'h8000);
                3: send_sample(16'h7FFF);
                4: send_sample(16'hAAAA);
                5: send_sample(16'h5555);
                6: send_sample(16'h0001);
                default: send_sample(16'hFFFE);
            endcase
        end
        drain();
    endtask

    // Out-of-range registers (clamped), zero levels, zero and oversized steps.
    task automatic test_register_limits();
        int n;
        set_idling(35, 35);
        run_frames(0, 0, 0, 0, 0, 3, n);             // everything clamps to one sample
        run_frames(1, 7, 4, 255, 257, 1, n);         // single column, most levels
        run_frames(3, 2, 7, 3, 65536, 1, n);         // q*step runs past 1.0
        run_frames(5, 2, 5, 2, 131071, 1, n);        // largest step field
        run_frames(2, 3, 1, 1, 65536, 2, n);         // reset-like quantizer
    endtask

    // Random small geometries and quantizers, rotating through the idle patterns.
    task automatic test_random_frames();
        int total, n, k;
        longint w, h, nc, lv, lv_eff, step;
        total = 0;
        k = 0;
        while (total < 380) begin
            case (k % 4)
                0: set_idling(0, 0);
                1: set_idling(61, 0);
                2: set_idling(0, 61);
                default: set_idling(35, 35);
            endcase
            case ($urandom_range(9))
                0:       w = 0;
                1:       w = longint'($urandom_range(9, 40));
                default: w = longint'($urandom_range(1, 8));
            endcase
            h = ($urandom_range(9) == 0) ? 0
                                         : longint'($urandom_range(1, (w > 8) ? 2 : 6));
            nc = longint'($urandom_range(0, 7));
            case ($urandom_range(5))
                0:       lv = 0;
                1:       lv = 255;
                2:       lv = 1;
                default: lv = longint'($urandom_range(0, 255));
            endcase
            lv_eff = (lv == 0) ? 1 : lv;
            step = ($urandom_range(9) == 0) ? longint'($urandom_range(0, 131071))
                                            : (UNIT + lv_eff / 2) / lv_eff;
            run_frames(w, h, nc, lv, step, $urandom_range(1, 2), n);
            total += n;
            k++;
        end
    endtask

    // Width and height registers above their limits clamp to the maximum, so
    // the frame never ends and no setting may follow this test.
    task automatic test_full_width();
        longint lv;
        lv = longint'($urandom_range(2, 16));
        set_idling(35, 35);
        apply_setting(2047, 2047, 1, 32'(lv), 32'((UNIT + lv / 2) / lv));
        run_samples(120);
        drain();
    endtask

    initial begin
        model_reset();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_corner_samples();
        test_register_limits();
        test_random_frames();
        test_full_width();

        // wait longer than a request takes, for stray results
        repeat (30) @(posedge clk);
        if (awaited_results.size() != 0)
            note_mismatch($sformatf("%0d results never arrived", awaited_results.size()));

        $display("summary: %0d requests over %0d register settings, %0d results checked",
                 requests_sent, settings_applied, results_checked);
        $display("summary: %0d frame ends, idling none/sender/receiver/both, widths to %0d",
                 frame_ends_seen, GRID_W);
        if (mismatch_count == 0)
            $display("error_diffusion_dither_tb: clean");
        else
            $display("error_diffusion_dither_tb: errors");
        $finish;
    end

    // watchdog: far beyond the slowest legal run
    initial begin
        #10_000_000;
        $display("timeout with %0d results outstanding", awaited_results.size());
        $display("error_diffusion_dither_tb: errors");
        $finish;
    end

endmodule
